/* rtl/wheel_power_limiter_unit_defines.svh */
// ----------------------------------------------------------------------------
// Wheel power limiter assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WHEEL_POWER_LIMITER_UNIT_DEFINES_SVH
`define WHEEL_POWER_LIMITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define WPL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("wheel power limiter assertion failed");
// Check a property at every rising edge, reset included.
`define WPL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("wheel power limiter assertion failed");
`else
`define WPL_ASSERT(lbl, clk, rstn, prop)
`define WPL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/wpl_pkg.sv */
// ----------------------------------------------------------------------------
// Wheel power limiter package
// Widths, register codes, reset values and the job record of the limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package wpl_pkg;

    localparam int NUM_WHEELS = 4;

    localparam int CUR_W      = 16;
    localparam int SPD_W      = 16;
    localparam int CAP_W      = 15;
    localparam int REF_W      = 16;
    localparam int CORR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int PRD_W  = 32;              // i*w, i*i, w*w
    localparam int TRM_W  = 57;              // coefficient times product
    localparam int B_W    = 41;              // torque_coeff * w
    localparam int PW_W   = 27;              // wheel power, 1/256 W
    localparam int RAW_W  = PW_W + 32;       // model sum before the shift
    localparam int TOT_W  = PW_W - 1 + $clog2(NUM_WHEELS);
    localparam int LQ_W   = 18;              // limit in 1/256 W minus correction
    localparam int HR_W   = 17;
    localparam int BUD_W  = 19;
    localparam int PLQ_W  = 26;
    localparam int PL_W   = 17;
    localparam int EST_W  = 25;
    localparam int PROD_W = PW_W + BUD_W;    // power times budget
    localparam int MAG_W  = PROD_W - 1;
    localparam int DCNT_W = $clog2(MAG_W);
    localparam int M_W    = 18;              // search current
    localparam int RHS_W  = 32;
    localparam int CMP_W  = RHS_W + 32;
    localparam int VTX_W  = 48;
    localparam int K_W    = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
    localparam int QDEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LOSS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_LOSS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_HR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_HR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP      = 3'd7;

    localparam logic [23:0] RST_TORQUE     = 24'd2195600;
    localparam logic [23:0] RST_SPEED_LOSS = 24'd159759;
    localparam logic [23:0] RST_CUR_LOSS   = 24'd135240;
    localparam logic [15:0] RST_STATIC     = 16'd1045;
    localparam logic [14:0] RST_CAP_MIN    = 15'd1250;
    localparam logic [15:0] RST_NORMAL_HR  = 16'd1280;
    localparam logic [16:0] RST_BOOST_HR   = 17'd51200;
    localparam logic [14:0] RST_CLAMP      = 15'd16000;

    localparam logic [REF_W-1:0] REF_MIN     = 16'd45;
    localparam logic [REF_W-1:0] REF_MAX     = 16'd220;
    localparam logic [7:0]       REF_DEFAULT = 8'd39;
    localparam logic [7:0]       PL_SCALE    = 8'd100;
    localparam int               EST_MAX     = 16777215;
    localparam int               RHS_MAX     = 1073741824;

    typedef struct packed {
        logic [23:0] torque_coeff;
        logic [23:0] speed_loss_coeff;
        logic [23:0] current_loss_coeff;
        logic [15:0] static_loss;
        logic [14:0] cap_min_voltage;
        logic [15:0] normal_headroom;
        logic [16:0] boost_headroom;
        logic [14:0] current_clamp;
    } t_cfg;

    typedef struct packed {
        logic [NUM_WHEELS-1:0][CUR_W-1:0] cur;
        logic [NUM_WHEELS-1:0][SPD_W-1:0] spd;
        logic [NUM_WHEELS-1:0][PW_W-1:0]  pw;
        logic [NUM_WHEELS-1:0][TRM_W-1:0] sq;
        logic [NUM_WHEELS-1:0][B_W-1:0]   b;
        logic [TOT_W-1:0]                 total;
        logic [BUD_W-1:0]                 budget;
        logic [PL_W-1:0]                  plim;
        logic [EST_W-1:0]                 est;
        logic                             limited;
    } t_job;

endpackage

`default_nettype wire

/* rtl/wpl_ifs.sv */
// ----------------------------------------------------------------------------
// Wheel power limiter channels
// Command, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpl_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [wpl_pkg::NUM_WHEELS*wpl_pkg::CUR_W-1:0] current;
    logic [wpl_pkg::NUM_WHEELS*wpl_pkg::SPD_W-1:0] speed;
    logic [wpl_pkg::CAP_W-1:0]                 cap_voltage;
    logic                                      boost_request;
    logic [wpl_pkg::REF_W-1:0]                 referee_limit;
    logic [wpl_pkg::CORR_W-1:0]                buffer_correction;

    modport source (output valid, current, speed, cap_voltage, boost_request,
                    referee_limit, buffer_correction, input ready);
    modport sink   (input valid, current, speed, cap_voltage, boost_request,
                    referee_limit, buffer_correction, output ready);
endinterface

interface wpl_out_if;
    logic                                      valid;
    logic                                      ready;
    logic [wpl_pkg::NUM_WHEELS*wpl_pkg::CUR_W-1:0] limited_current;
    logic [wpl_pkg::PL_W-1:0]                  power_limit;
    logic [wpl_pkg::EST_W-1:0]                 estimated_power;
    logic                                      was_limited;

    modport source (output valid, limited_current, power_limit, estimated_power,
                    was_limited, input ready);
    modport sink   (input valid, limited_current, power_limit, estimated_power,
                    was_limited, output ready);
endinterface

interface wpl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wpl_pkg::CFG_IDX_W-1:0]    index;
    logic [wpl_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/wpl_front.sv */
// ----------------------------------------------------------------------------
// Wheel power limiter front end
// Four-stage pipeline: wheel power estimate, power sum, budget and limit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wpl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    wpl_in_if.sink             i_in,
    input  wire wpl_pkg::t_cfg i_cfg,
    output wpl_pkg::t_job      o_job,
    output logic               o_valid,
    input  wire logic          i_ready
);

    localparam int NW = wpl_pkg::NUM_WHEELS;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [wpl_pkg::CUR_W-1:0] r1_cur [NW];
    logic signed [wpl_pkg::SPD_W-1:0] r1_spd [NW];
    logic signed [wpl_pkg::PRD_W-1:0] r1_piw [NW];
    logic signed [wpl_pkg::PRD_W-1:0] r1_i2  [NW];
    logic signed [wpl_pkg::PRD_W-1:0] r1_w2  [NW];
    logic signed [wpl_pkg::LQ_W-1:0]  r1_lq8;
    logic        [wpl_pkg::HR_W-1:0]  r1_hr;

    logic signed [wpl_pkg::CUR_W-1:0] r2_cur [NW];
    logic signed [wpl_pkg::SPD_W-1:0] r2_spd [NW];
    logic signed [wpl_pkg::TRM_W-1:0] r2_tq  [NW];
    logic signed [wpl_pkg::TRM_W-1:0] r2_sl  [NW];
    logic signed [wpl_pkg::TRM_W-1:0] r2_cl  [NW];
    logic signed [wpl_pkg::B_W-1:0]   r2_b   [NW];
    logic signed [wpl_pkg::BUD_W-1:0] r2_budget;
    logic signed [wpl_pkg::PLQ_W-1:0] r2_plq;

    logic signed [wpl_pkg::CUR_W-1:0] r3_cur [NW];
    logic signed [wpl_pkg::SPD_W-1:0] r3_spd [NW];
    logic signed [wpl_pkg::PW_W-1:0]  r3_pw  [NW];
    logic signed [wpl_pkg::TRM_W-1:0] r3_sl  [NW];
    logic signed [wpl_pkg::B_W-1:0]   r3_b   [NW];
    logic signed [wpl_pkg::BUD_W-1:0] r3_budget;
    logic        [wpl_pkg::PL_W-1:0]  r3_plim;

    wpl_pkg::t_job r4_job;

    logic signed [wpl_pkg::CUR_W-1:0] n1_cur [NW];
    logic signed [wpl_pkg::SPD_W-1:0] n1_spd [NW];
    logic signed [wpl_pkg::LQ_W-1:0]  n1_lq8;
    logic        [wpl_pkg::HR_W-1:0]  n1_hr;
    logic signed [wpl_pkg::RAW_W-1:0] n3_raw [NW];
    logic        [wpl_pkg::PLQ_W-1:0] n3_plq;
    logic        [wpl_pkg::TOT_W-1:0] n4_total;

    function automatic logic [wpl_pkg::PLQ_W-1:0] PLQ_W_ADD(
        input logic [wpl_pkg::PLQ_W-1:0] v);
        return v + wpl_pkg::PLQ_W'(255);
    endfunction

    assign en         = !r_v4 || i_ready;
    assign i_in.ready = en;
    assign o_valid    = r_v4;
    assign o_job      = r4_job;

    always_comb begin
        logic [7:0] lim;
        for (int k = 0; k < NW; k++) begin
            n1_cur[k] = $signed(i_in.current[k*wpl_pkg::CUR_W +: wpl_pkg::CUR_W]);
            n1_spd[k] = $signed(i_in.speed[k*wpl_pkg::SPD_W +: wpl_pkg::SPD_W]);
        end
        // out-of-range referee limits fall back to the default
        if (i_in.referee_limit >= wpl_pkg::REF_MIN && i_in.referee_limit <= wpl_pkg::REF_MAX) begin
            lim = i_in.referee_limit[7:0];
        end else begin
            lim = wpl_pkg::REF_DEFAULT;
        end
        n1_lq8 = $signed({1'b0, lim, 8'd0}) - $signed(i_in.buffer_correction);
        if (i_in.cap_voltage > i_cfg.cap_min_voltage) begin
            n1_hr = i_in.boost_request ? i_cfg.boost_headroom : {1'b0, i_cfg.normal_headroom};
        end else begin
            n1_hr = '0;
        end
    end

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            n3_raw[k] = r2_tq[k] + r2_sl[k] + r2_cl[k];
        end
        // round toward zero on the divide by 256
        n3_plq = r2_plq[wpl_pkg::PLQ_W-1] ? PLQ_W_ADD(r2_plq) : r2_plq;
    end

    always_comb begin
        n4_total = '0;
        for (int k = 0; k < NW; k++) begin
            if (!r3_pw[k][wpl_pkg::PW_W-1]) begin
                n4_total = n4_total + wpl_pkg::TOT_W'(r3_pw[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NW; k++) begin
                // stage 1: narrow products
                r1_cur[k] <= n1_cur[k];
                r1_spd[k] <= n1_spd[k];
                r1_piw[k] <= n1_cur[k] * n1_spd[k];
                r1_i2[k]  <= n1_cur[k] * n1_cur[k];
                r1_w2[k]  <= n1_spd[k] * n1_spd[k];
                // stage 2: coefficient products
                r2_cur[k] <= r1_cur[k];
                r2_spd[k] <= r1_spd[k];
                r2_tq[k]  <= $signed({1'b0, i_cfg.torque_coeff}) * r1_piw[k];
                r2_sl[k]  <= $signed({1'b0, i_cfg.speed_loss_coeff}) * r1_w2[k];
                r2_cl[k]  <= $signed({1'b0, i_cfg.current_loss_coeff}) * r1_i2[k];
                r2_b[k]   <= $signed({1'b0, i_cfg.torque_coeff}) * r1_spd[k];
                // stage 3: floor shift and static loss
                r3_cur[k] <= r2_cur[k];
                r3_spd[k] <= r2_spd[k];
                r3_pw[k]  <= $signed(n3_raw[k][wpl_pkg::RAW_W-1:32])
                             + $signed({1'b0, i_cfg.static_loss});
                r3_sl[k]  <= r2_sl[k];
                r3_b[k]   <= r2_b[k];
                // stage 4: job record
                r4_job.cur[k] <= r3_cur[k];
                r4_job.spd[k] <= r3_spd[k];
                r4_job.pw[k]  <= r3_pw[k];
                r4_job.sq[k]  <= r3_sl[k];
                r4_job.b[k]   <= r3_b[k];
            end
            r1_lq8    <= n1_lq8;
            r1_hr     <= n1_hr;
            r2_budget <= r1_lq8 + $signed({1'b0, r1_hr});
            r2_plq    <= r1_lq8 * $signed({1'b0, wpl_pkg::PL_SCALE});
            r3_budget <= r2_budget;
            r3_plim   <= n3_plq[wpl_pkg::PL_W+7:8];
            r4_job.total   <= n4_total;
            r4_job.budget  <= r3_budget;
            r4_job.plim    <= r3_plim;
            r4_job.limited <= $signed({1'b0, n4_total}) > r3_budget;
            r4_job.est     <= (n4_total > wpl_pkg::TOT_W'(wpl_pkg::EST_MAX))
                              ? wpl_pkg::EST_W'(wpl_pkg::EST_MAX) : wpl_pkg::EST_W'(n4_total);
        end
    end

endmodule

`default_nettype wire

/* rtl/wpl_queue.sv */
// ----------------------------------------------------------------------------
// Wheel power limiter job queue
// Two-entry FIFO of job records between the front end and the solver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wheel_power_limiter_unit_defines.svh"

module wpl_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire wpl_pkg::t_job i_data,
    output logic               o_ready,
    output logic               o_valid,
    output wpl_pkg::t_job      o_data,
    input  wire logic          i_pop
);

    localparam int PTR_W = (wpl_pkg::QDEPTH > 1) ? $clog2(wpl_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(wpl_pkg::QDEPTH + 1);

    wpl_pkg::t_job r_mem [wpl_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_ready = r_count != CNT_W'(wpl_pkg::QDEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(wpl_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= adv(r_wr);
            if (i_pop)  r_rd <= adv(r_rd);
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    `WPL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(wpl_pkg::QDEPTH))
    `WPL_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> (r_count != '0))

endmodule

`default_nettype wire

/* rtl/wpl_back.sv */
// ----------------------------------------------------------------------------
// Wheel power limiter back end
// Sequencer with shared divider and quadratic evaluator for the current search.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wheel_power_limiter_unit_defines.svh"

module wpl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire wpl_pkg::t_cfg i_cfg,
    input  wire wpl_pkg::t_job i_job,
    input  wire logic          i_valid,
    output logic               o_pop,
    wpl_out_if.source          o_out
);

    localparam int NW = wpl_pkg::NUM_WHEELS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_DSET = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_TGT  = 4'd4;
    localparam logic [3:0] ST_E0   = 4'd5;
    localparam logic [3:0] ST_E1   = 4'd6;
    localparam logic [3:0] ST_E2   = 4'd7;
    localparam logic [3:0] ST_E3   = 4'd8;
    localparam logic [3:0] ST_NEXT = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0]                          r_state;
    logic [wpl_pkg::K_W-1:0]             r_k;
    logic                                r_ovalid;
    wpl_pkg::t_job                       r_job;
    logic signed [wpl_pkg::CUR_W-1:0]    r_cur [NW];
    logic signed [wpl_pkg::PROD_W-1:0]   r_prod;
    logic        [wpl_pkg::MAG_W-1:0]    r_num;
    logic        [wpl_pkg::TOT_W-1:0]    r_rem;
    logic        [wpl_pkg::DCNT_W-1:0]   r_dcnt;
    logic                                r_neg;
    logic signed [wpl_pkg::RHS_W-1:0]    r_rhs;
    logic signed [wpl_pkg::M_W-1:0]      r_lo, r_hi, r_m;
    logic                                r_init, r_pos;
    logic signed [wpl_pkg::M_W+wpl_pkg::SPD_W-1:0] r_p1;
    logic signed [2*wpl_pkg::M_W-1:0]    r_p2;
    logic signed [wpl_pkg::CMP_W-1:0]    r_t1, r_t2;
    logic signed [wpl_pkg::VTX_W-1:0]    r_vtx;
    logic [wpl_pkg::NUM_WHEELS*wpl_pkg::CUR_W-1:0] r_olc;
    logic [wpl_pkg::PL_W-1:0]            r_opl;
    logic [wpl_pkg::EST_W-1:0]           r_oest;
    logic                                r_olim;

    logic signed [wpl_pkg::SPD_W-1:0]    sel_spd;
    logic signed [wpl_pkg::PW_W-1:0]     sel_pw;
    logic signed [wpl_pkg::TRM_W-1:0]    sel_sq;
    logic signed [wpl_pkg::B_W-1:0]      sel_b;
    logic signed [wpl_pkg::CUR_W-1:0]    sel_cmd;
    logic signed [wpl_pkg::M_W-1:0]      clamp_s;
    logic        [wpl_pkg::TOT_W:0]      rem_sh;
    logic                                rem_ge;
    logic signed [wpl_pkg::MAG_W:0]      rhs_diff;
    logic signed [wpl_pkg::VTX_W-1:0]    vsum;
    logic signed [wpl_pkg::CMP_W-1:0]    fsum;
    logic                                pred;
    logic signed [wpl_pkg::M_W-1:0]      lo_n, hi_n, mid_n;

    assign o_pop                 = (r_state == ST_IDLE) && i_valid;
    assign o_out.valid           = r_ovalid;
    assign o_out.limited_current = r_olc;
    assign o_out.power_limit     = r_opl;
    assign o_out.estimated_power = r_oest;
    assign o_out.was_limited     = r_olim;

    always_comb begin
        sel_spd = $signed(r_job.spd[r_k]);
        sel_pw  = $signed(r_job.pw[r_k]);
        sel_sq  = $signed(r_job.sq[r_k]);
        sel_b   = $signed(r_job.b[r_k]);
        sel_cmd = $signed(r_job.cur[r_k]);
        clamp_s = $signed({{(wpl_pkg::M_W-15){1'b0}}, i_cfg.current_clamp});
        rem_sh  = {r_rem, r_num[wpl_pkg::MAG_W-1]};
        rem_ge  = rem_sh >= {1'b0, r_job.total};
        rhs_diff = $signed({1'b0, r_num}) - $signed({1'b0, i_cfg.static_loss});
    end

    // search step: vertex side test or exact power test
    always_comb begin
        vsum = r_vtx + sel_b;
        fsum = r_t1 + sel_sq + r_t2;
        pred = (r_pos ? (vsum <= 0) : (vsum >= 0)) || (fsum <= $signed({r_rhs, 32'd0}));
        if (r_init) begin
            lo_n = r_lo;
            hi_n = r_hi;
        end else if (r_pos) begin
            lo_n = pred ? r_m : r_lo;
            hi_n = pred ? r_hi : r_m - 1'b1;
        end else begin
            lo_n = pred ? r_lo : r_m + 1'b1;
            hi_n = pred ? r_m : r_hi;
        end
        if (r_pos) begin
            mid_n = lo_n + ((hi_n - lo_n + 1'b1) >>> 1);
        end else begin
            mid_n = lo_n + ((hi_n - lo_n) >>> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // load a finished job into the result slot, else drop a taken beat
            if (r_state == ST_DONE && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= (i_job.limited && i_job.total != '0) ? ST_MUL : ST_DONE;
                    end
                end
                ST_MUL:  r_state <= ST_DSET;
                ST_DSET: r_state <= ST_DIV;
                ST_DIV:  if (r_dcnt == '0) r_state <= ST_TGT;
                ST_TGT:  r_state <= (r_neg && r_num != '0) ? ST_NEXT : ST_E0;
                ST_E0:   r_state <= ST_E1;
                ST_E1:   r_state <= ST_E2;
                ST_E2:   r_state <= ST_E3;
                ST_E3: begin
                    if ((r_init && !pred) || !(lo_n < hi_n)) begin
                        r_state <= ST_NEXT;
                    end else begin
                        r_state <= ST_E0;
                    end
                end
                ST_NEXT: begin
                    r_state <= (r_k == wpl_pkg::K_W'(NW - 1)) ? ST_DONE : ST_MUL;
                end
                ST_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job <= i_job;
                r_k   <= '0;
                for (int k = 0; k < NW; k++) r_cur[k] <= $signed(i_job.cur[k]);
            end
            ST_MUL: r_prod <= sel_pw * $signed(r_job.budget);
            ST_DSET: begin
                r_neg  <= r_prod[wpl_pkg::PROD_W-1];
                r_num  <= r_prod[wpl_pkg::PROD_W-1] ? wpl_pkg::MAG_W'(-r_prod)
                                                    : wpl_pkg::MAG_W'(r_prod);
                r_rem  <= '0;
                r_dcnt <= wpl_pkg::DCNT_W'(wpl_pkg::MAG_W - 1);
            end
            ST_DIV: begin
                // one quotient bit per cycle, shifted in behind the dividend
                r_rem  <= rem_ge ? wpl_pkg::TOT_W'(rem_sh - {1'b0, r_job.total})
                                 : rem_sh[wpl_pkg::TOT_W-1:0];
                r_num  <= {r_num[wpl_pkg::MAG_W-2:0], rem_ge};
                r_dcnt <= r_dcnt - 1'b1;
            end
            ST_TGT: begin
                r_rhs  <= (rhs_diff > wpl_pkg::RHS_MAX) ? wpl_pkg::RHS_W'(wpl_pkg::RHS_MAX)
                                                        : wpl_pkg::RHS_W'(rhs_diff);
                r_pos  <= sel_cmd > 0;
                r_lo   <= -clamp_s;
                r_hi   <= clamp_s;
                r_m    <= (sel_cmd > 0) ? -clamp_s : clamp_s;
                r_init <= 1'b1;
            end
            ST_E0: begin
                r_p1 <= r_m * sel_spd;
                r_p2 <= r_m * r_m;
            end
            ST_E1: begin
                r_t1  <= $signed({1'b0, i_cfg.torque_coeff}) * r_p1;
                r_vtx <= $signed({1'b0, i_cfg.current_loss_coeff, 1'b0}) * r_m;
            end
            ST_E2: r_t2 <= $signed({1'b0, i_cfg.current_loss_coeff}) * r_p2;
            ST_E3: begin
                r_init <= 1'b0;
                r_lo   <= lo_n;
                r_hi   <= hi_n;
                r_m    <= mid_n;
                if (r_init && !pred) begin
                    r_cur[r_k] <= wpl_pkg::CUR_W'(r_pos ? -clamp_s : clamp_s);
                end else if (!(lo_n < hi_n)) begin
                    r_cur[r_k] <= wpl_pkg::CUR_W'(lo_n);
                end
            end
            ST_NEXT: r_k <= r_k + 1'b1;
            ST_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    for (int k = 0; k < NW; k++) begin
                        r_olc[k*wpl_pkg::CUR_W +: wpl_pkg::CUR_W] <= r_cur[k];
                    end
                    r_opl  <= r_job.plim;
                    r_oest <= r_job.est;
                    r_olim <= r_job.limited;
                end
            end
            default: ;
        endcase
    end

    `WPL_ASSERT(a_search_order, i_clk, i_rst_n, (r_state == ST_E3 && !r_init) |-> (r_lo <= r_hi))
    `WPL_ASSERT(a_div_exit, i_clk, i_rst_n, (r_state == ST_DIV && r_dcnt == '0) |=> (r_state == ST_TGT))
    `WPL_ASSERT(a_result_source, i_clk, i_rst_n, $rose(r_ovalid) |-> ($past(r_state) == ST_DONE))

endmodule

`default_nettype wire

/* rtl/wheel_power_limiter_unit.sv */
// ----------------------------------------------------------------------------
// Wheel power limiter
// Chassis power estimate and per-wheel current limiting with register port.
// ----------------------------------------------------------------------------
// Each command beat carries one current command and one speed per wheel plus
// the capacitor voltage, boost request, referee limit and buffer correction;
// each result beat returns the limited currents, the power limit for the
// capacitor board, the estimated power and the limited flag, in order. The
// front end is a four-stage pipeline that takes one beat per cycle, unless a
// full queue holds back its last stage, into a two-entry job queue. The back
// end works one job at a time: an unlimited beat goes straight to its result;
// a limited one runs, per wheel, the scaling multiply, a bit-serial divider,
// then the evaluations of the current search (one check plus up to
// ceil(log2(2*clamp+1)) halving steps, 17 evaluations at most) and a step to
// the next wheel. That shared divider and quadratic evaluator set the
// sustained rate of limited beats. Registers are to be written over the
// config channel only while the block is idle, which the user must ensure;
// the block itself does not enforce it and is always ready.
`default_nettype none

module wheel_power_limiter_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wpl_in_if.sink    i_in,
    wpl_out_if.source o_out,
    wpl_cfg_if.sink   i_cfg
);

    wpl_pkg::t_cfg r_cfg;
    wpl_pkg::t_job front_job, queue_job;
    logic          front_valid, queue_ready, queue_valid, back_pop;

    // register writes complete every cycle
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.torque_coeff       <= wpl_pkg::RST_TORQUE;
            r_cfg.speed_loss_coeff   <= wpl_pkg::RST_SPEED_LOSS;
            r_cfg.current_loss_coeff <= wpl_pkg::RST_CUR_LOSS;
            r_cfg.static_loss        <= wpl_pkg::RST_STATIC;
            r_cfg.cap_min_voltage    <= wpl_pkg::RST_CAP_MIN;
            r_cfg.normal_headroom    <= wpl_pkg::RST_NORMAL_HR;
            r_cfg.boost_headroom     <= wpl_pkg::RST_BOOST_HR;
            r_cfg.current_clamp      <= wpl_pkg::RST_CLAMP;
        end else if (i_cfg.valid) begin
            // drop data bits above each register's width
            unique case (i_cfg.index)
                wpl_pkg::CFG_TORQUE:     r_cfg.torque_coeff       <= i_cfg.data;
                wpl_pkg::CFG_SPEED_LOSS: r_cfg.speed_loss_coeff   <= i_cfg.data;
                wpl_pkg::CFG_CUR_LOSS:   r_cfg.current_loss_coeff <= i_cfg.data;
                wpl_pkg::CFG_STATIC:     r_cfg.static_loss        <= i_cfg.data[15:0];
                wpl_pkg::CFG_CAP_MIN:    r_cfg.cap_min_voltage    <= i_cfg.data[14:0];
                wpl_pkg::CFG_NORMAL_HR:  r_cfg.normal_headroom    <= i_cfg.data[15:0];
                wpl_pkg::CFG_BOOST_HR:   r_cfg.boost_headroom     <= i_cfg.data[16:0];
                wpl_pkg::CFG_CLAMP:      r_cfg.current_clamp      <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // front end: estimate, sum and classify each beat
    wpl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_job   (front_job),
        .o_valid (front_valid),
        .i_ready (queue_ready)
    );

    // hold jobs so the front end keeps accepting while the solver is busy
    wpl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid && queue_ready),
        .i_data  (front_job),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_data  (queue_job),
        .i_pop   (back_pop)
    );

    // back end: scale powers and search limited currents
    wpl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_job   (queue_job),
        .i_valid (queue_valid),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
